// ===== rtl/eil4hp_pkg.sv =====
`timescale 1ns / 1ps

package eil4hp_pkg;

   // Frame classification codes carried on the result channel.
   localparam logic [3:0] CLASS_SHORT     = 4'd0;
   localparam logic [3:0] CLASS_NON_IP    = 4'd1;
   localparam logic [3:0] CLASS_IP_TRUNC  = 4'd2;
   localparam logic [3:0] CLASS_IHL_TRUNC = 4'd3;
   localparam logic [3:0] CLASS_TCP_TRUNC = 4'd4;
   localparam logic [3:0] CLASS_UDP_TRUNC = 4'd5;
   localparam logic [3:0] CLASS_TCP       = 4'd6;
   localparam logic [3:0] CLASS_UDP       = 4'd7;
   localparam logic [3:0] CLASS_OTHER     = 4'd8;

   // Byte offsets and minimum header sizes.
   localparam int unsigned ETH_HDR_BYTES = 14;
   localparam int unsigned IP_MIN_BYTES  = 20;
   localparam int unsigned TCP_MIN_BYTES = 20;
   localparam int unsigned UDP_MIN_BYTES = 8;
   localparam int unsigned SRC_MAC_START = 6;
   localparam int unsigned IHL_OFFSET    = 14;
   localparam int unsigned PROTO_OFFSET  = 23;
   localparam int unsigned SRC_IP_START  = 26;
   localparam int unsigned DST_IP_START  = 30;
   localparam int unsigned DST_IP_END    = 34;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam int unsigned FRAME_LENGTH_W = 14;

endpackage

// ===== rtl/eth_ipv4_l4_header_parser_unit.sv =====
`timescale 1ns / 1ps

// Ethernet / IPv4 / TCP-UDP header parser.
//
// The request channel carries a captured frame one byte per transfer, first
// byte first, with req_last_byte set on the final byte. The response channel
// carries one classification record per frame, produced by the transfer of
// the last byte: class, MAC addresses, ethertype, IPv4 protocol and
// addresses, the TCP or UDP ports, and the saturated frame length.
//
// Each of the first MAX_FRAME_BYTES bytes of a frame is captured into the
// field registers in the cycle it is transferred. The record appears on
// the response channel in the cycle after the last byte's transfer. One byte
// is taken per cycle while req_stall is low, and frames may follow each
// other with no gap.
//
// Reset clears the byte counter, all captured fields and the response valid
// flag. While a record is held and rsp_stall is high, req_stall is
// raised; otherwise the block keeps taking bytes while a record waits.
module eth_ipv4_l4_header_parser_unit
   import eil4hp_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 16383
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_frame_class,
   output logic [47:0] rsp_source_mac,
   output logic [47:0] rsp_dest_mac,
   output logic [15:0] rsp_ether_kind,
   output logic [7:0]  rsp_ip_protocol,
   output logic [31:0] rsp_source_ip,
   output logic [31:0] rsp_dest_ip,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic [FRAME_LENGTH_W-1:0] rsp_frame_length
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned LEN_W = (CNT_W > FRAME_LENGTH_W) ? CNT_W : FRAME_LENGTH_W;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_FRAME_BYTES);

   // Frame capture state.
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [47:0]      dst_mac_ff, dst_mac_in;
   logic [47:0]      src_mac_ff, src_mac_in;
   logic [15:0]      ethertype_ff, ethertype_in;
   logic [3:0]       header_words_ff, header_words_in;
   logic [7:0]       protocol_ff, protocol_in;
   logic [31:0]      src_ip_ff, src_ip_in;
   logic [31:0]      dst_ip_ff, dst_ip_in;
   logic [15:0]      src_port_ff, src_port_in;
   logic [15:0]      dst_port_ff, dst_port_in;

   // Response register.
   logic        rsp_valid_ff;
   logic [3:0]  rsp_class_ff;
   logic [47:0] rsp_src_mac_ff;
   logic [47:0] rsp_dst_mac_ff;
   logic [15:0] rsp_ethertype_ff;
   logic [7:0]  rsp_protocol_ff;
   logic [31:0] rsp_src_ip_ff;
   logic [31:0] rsp_dst_ip_ff;
   logic [15:0] rsp_src_port_ff;
   logic [15:0] rsp_dst_port_ff;
   logic [FRAME_LENGTH_W-1:0] rsp_length_ff;

   logic             req_fire;
   logic             frame_done;
   logic             capture_en;
   logic [CNT_W-1:0] idx;
   logic [3:0]       hw_eff;
   logic [CNT_W-1:0] port_pos;
   logic [CNT_W-1:0] ip_hdr_end;
   logic [3:0]       frame_class;
   logic             ports_ok;
   logic             l3_ok;
   logic             l2_ok;

   // The only thing that can block a byte is a record that cannot leave.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_fire   = req_valid & ~req_stall;
   assign frame_done = req_fire & req_last_byte;
   assign idx        = byte_count_ff;
   assign capture_en = req_fire && (byte_count_ff < MAX_COUNT);

   // The header length nibble is usable in the same cycle it arrives, so the
   // port position follows byte 14 directly.
   assign hw_eff   = (idx == CNT_W'(IHL_OFFSET)) ? req_data_byte[3:0] : header_words_ff;
   assign port_pos = CNT_W'(ETH_HDR_BYTES) + CNT_W'({hw_eff, 2'b00});

   always_comb begin
      byte_count_in   = byte_count_ff;
      dst_mac_in      = dst_mac_ff;
      src_mac_in      = src_mac_ff;
      ethertype_in    = ethertype_ff;
      header_words_in = header_words_ff;
      protocol_in     = protocol_ff;
      src_ip_in       = src_ip_ff;
      dst_ip_in       = dst_ip_ff;
      src_port_in     = src_port_ff;
      dst_port_in     = dst_port_ff;
      if (capture_en) begin
         byte_count_in = byte_count_ff + CNT_W'(1);
         if (idx < CNT_W'(SRC_MAC_START)) begin
            dst_mac_in = {dst_mac_ff[39:0], req_data_byte};
         end else if (idx < CNT_W'(ETH_HDR_BYTES - 2)) begin
            src_mac_in = {src_mac_ff[39:0], req_data_byte};
         end else if (idx < CNT_W'(ETH_HDR_BYTES)) begin
            ethertype_in = {ethertype_ff[7:0], req_data_byte};
         end
         if (idx == CNT_W'(IHL_OFFSET)) begin
            header_words_in = req_data_byte[3:0];
         end
         if (idx == CNT_W'(PROTO_OFFSET)) begin
            protocol_in = req_data_byte;
         end
         if (idx >= CNT_W'(SRC_IP_START) && idx < CNT_W'(DST_IP_START)) begin
            src_ip_in = {src_ip_ff[23:0], req_data_byte};
         end
         if (idx >= CNT_W'(DST_IP_START) && idx < CNT_W'(DST_IP_END)) begin
            dst_ip_in = {dst_ip_ff[23:0], req_data_byte};
         end
         if (idx == port_pos || idx == port_pos + CNT_W'(1)) begin
            src_port_in = {src_port_ff[7:0], req_data_byte};
         end
         if (idx == port_pos + CNT_W'(2) || idx == port_pos + CNT_W'(3)) begin
            dst_port_in = {dst_port_ff[7:0], req_data_byte};
         end
      end
   end

   // Classification on the updated state, so the last byte counts too.
   assign ip_hdr_end = CNT_W'(ETH_HDR_BYTES) + CNT_W'({header_words_in, 2'b00});

   always_comb begin
      if (byte_count_in < CNT_W'(ETH_HDR_BYTES)) begin
         frame_class = CLASS_SHORT;
      end else if (ethertype_in != ETHERTYPE_IPV4) begin
         frame_class = CLASS_NON_IP;
      end else if (byte_count_in < CNT_W'(ETH_HDR_BYTES + IP_MIN_BYTES)) begin
         frame_class = CLASS_IP_TRUNC;
      end else if (byte_count_in < ip_hdr_end) begin
         frame_class = CLASS_IHL_TRUNC;
      end else if (protocol_in == PROTO_TCP) begin
         frame_class = (byte_count_in < ip_hdr_end + CNT_W'(TCP_MIN_BYTES))
                       ? CLASS_TCP_TRUNC : CLASS_TCP;
      end else if (protocol_in == PROTO_UDP) begin
         frame_class = (byte_count_in < ip_hdr_end + CNT_W'(UDP_MIN_BYTES))
                       ? CLASS_UDP_TRUNC : CLASS_UDP;
      end else begin
         frame_class = CLASS_OTHER;
      end
   end

   // Fields that have no meaning for a class are reported as zero.
   assign l2_ok    = (frame_class != CLASS_SHORT);
   assign l3_ok    = (frame_class >= CLASS_TCP_TRUNC);
   assign ports_ok = (frame_class == CLASS_TCP) || (frame_class == CLASS_UDP);

   // Capture state; the last byte of a frame leaves it clear for the next.
   always_ff @(posedge clock) begin
      if (reset || frame_done) begin
         byte_count_ff   <= '0;
         dst_mac_ff      <= '0;
         src_mac_ff      <= '0;
         ethertype_ff    <= '0;
         header_words_ff <= '0;
         protocol_ff     <= '0;
         src_ip_ff       <= '0;
         dst_ip_ff       <= '0;
         src_port_ff     <= '0;
         dst_port_ff     <= '0;
      end else begin
         byte_count_ff   <= byte_count_in;
         dst_mac_ff      <= dst_mac_in;
         src_mac_ff      <= src_mac_in;
         ethertype_ff    <= ethertype_in;
         header_words_ff <= header_words_in;
         protocol_ff     <= protocol_in;
         src_ip_ff       <= src_ip_in;
         dst_ip_ff       <= dst_ip_in;
         src_port_ff     <= src_port_in;
         dst_port_ff     <= dst_port_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_class_ff     <= frame_class;
         rsp_src_mac_ff   <= l2_ok ? src_mac_in : '0;
         rsp_dst_mac_ff   <= l2_ok ? dst_mac_in : '0;
         rsp_ethertype_ff <= l2_ok ? ethertype_in : '0;
         rsp_protocol_ff  <= (frame_class >= CLASS_IP_TRUNC) ? protocol_in : '0;
         rsp_src_ip_ff    <= l3_ok ? src_ip_in : '0;
         rsp_dst_ip_ff    <= l3_ok ? dst_ip_in : '0;
         rsp_src_port_ff  <= ports_ok ? src_port_in : '0;
         rsp_dst_port_ff  <= ports_ok ? dst_port_in : '0;
         rsp_length_ff    <= FRAME_LENGTH_W'(LEN_W'(byte_count_in));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_class  = rsp_class_ff;
   assign rsp_source_mac   = rsp_src_mac_ff;
   assign rsp_dest_mac     = rsp_dst_mac_ff;
   assign rsp_ether_kind   = rsp_ethertype_ff;
   assign rsp_ip_protocol  = rsp_protocol_ff;
   assign rsp_source_ip    = rsp_src_ip_ff;
   assign rsp_dest_ip      = rsp_dst_ip_ff;
   assign rsp_source_port  = rsp_src_port_ff;
   assign rsp_dest_port    = rsp_dst_port_ff;
   assign rsp_frame_length = rsp_length_ff;

   // A last-byte transfer always produces a record in the next cycle.
   a_last_gives_record: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> rsp_valid_ff)
      else $error("last byte transfer did not produce a record");

   // The counter starts over after each frame.
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> byte_count_ff == '0)
      else $error("byte counter not cleared after a frame");

   // The counter saturates and never passes the maximum frame size.
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= MAX_COUNT)
      else $error("byte counter beyond maximum frame size");

   // Ports are reported only for complete TCP or UDP frames.
   a_ports_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(rsp_class_ff == CLASS_TCP || rsp_class_ff == CLASS_UDP)
      |-> rsp_src_port_ff == '0 && rsp_dst_port_ff == '0)
      else $error("ports reported for a class without ports");

endmodule

// ===== tb/eth_ipv4_l4_header_parser_unit_test.sv =====
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_unit_test;
   import eil4hp_pkg::*;

   // The DUT saturates its byte counter at this value. It is also the largest
   // value that the 14-bit length field can carry.
   localparam int unsigned FRAME_BYTE_LIMIT = 16383;
   // An IHL unit covers four bytes.
   localparam int unsigned WORD_BYTES = 4;
   // Watchdog. The frames are short and the total byte count is small, so a
   // correct run finishes far below this even under the heaviest stalls.
   localparam int unsigned CYCLE_LIMIT = 600000;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef struct packed {
      logic [3:0]                frame_class;
      logic [47:0]               source_mac;
      logic [47:0]               dest_mac;
      logic [15:0]               ether_kind;
      logic [7:0]                ip_protocol;
      logic [31:0]               source_ip;
      logic [31:0]               dest_ip;
      logic [15:0]               source_port;
      logic [15:0]               dest_port;
      logic [FRAME_LENGTH_W-1:0] frame_length;
   } frame_record_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_frame_class;
   logic [47:0] rsp_source_mac;
   logic [47:0] rsp_dest_mac;
   logic [15:0] rsp_ether_kind;
   logic [7:0]  rsp_ip_protocol;
   logic [31:0] rsp_source_ip;
   logic [31:0] rsp_dest_ip;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_dest_port;
   logic [FRAME_LENGTH_W-1:0] rsp_frame_length;

   // Bytes waiting to be offered on the request channel, and the records that
   // the frames already transferred must produce, oldest first.
   frame_byte_type   pending_bytes[$];
   frame_record_type records_due[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_queued;
   int unsigned frames_queued;

   // Header state of the frame in progress, as the parser should hold it.
   int unsigned seen_bytes = 0;
   logic [47:0] cap_dst_mac = '0;
   logic [47:0] cap_src_mac = '0;
   logic [15:0] cap_ether_kind = '0;
   logic [3:0]  cap_ihl = '0;
   logic [7:0]  cap_proto = '0;
   logic [31:0] cap_src_ip = '0;
   logic [31:0] cap_dst_ip = '0;
   logic [15:0] cap_src_port = '0;
   logic [15:0] cap_dst_port = '0;

   eth_ipv4_l4_header_parser_unit #(
      .MAX_FRAME_BYTES(FRAME_BYTE_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_class  (rsp_frame_class),
      .rsp_source_mac   (rsp_source_mac),
      .rsp_dest_mac     (rsp_dest_mac),
      .rsp_ether_kind   (rsp_ether_kind),
      .rsp_ip_protocol  (rsp_ip_protocol),
      .rsp_source_ip    (rsp_source_ip),
      .rsp_dest_ip      (rsp_dest_ip),
      .rsp_source_port  (rsp_source_port),
      .rsp_dest_port    (rsp_dest_port),
      .rsp_frame_length (rsp_frame_length)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Frame parser prediction. Each transferred byte is folded into the header
   // state; the last byte of a frame classifies it, queues the record that
   // the DUT must return, and clears the state for the next frame.
   task automatic parse_frame_byte(input logic [7:0] data, input logic last);
      int unsigned      ihl_now;
      int unsigned      port_at;
      int unsigned      hdr_len;
      logic [3:0]       cls;
      frame_record_type rec;
      // Bytes past the saturation point are counted no further and captured
      // nowhere.
      if (seen_bytes < FRAME_BYTE_LIMIT) begin
         if (seen_bytes < SRC_MAC_START) begin
            cap_dst_mac = {cap_dst_mac[39:0], data};
         end else if (seen_bytes < ETH_HDR_BYTES - 2) begin
            cap_src_mac = {cap_src_mac[39:0], data};
         end else if (seen_bytes < ETH_HDR_BYTES) begin
            cap_ether_kind = {cap_ether_kind[7:0], data};
         end
         if (seen_bytes == IHL_OFFSET) begin
            cap_ihl = data[3:0];
         end
         if (seen_bytes == PROTO_OFFSET) begin
            cap_proto = data;
         end
         if (seen_bytes >= SRC_IP_START && seen_bytes < DST_IP_START) begin
            cap_src_ip = {cap_src_ip[23:0], data};
         end
         if (seen_bytes >= DST_IP_START && seen_bytes < DST_IP_END) begin
            cap_dst_ip = {cap_dst_ip[23:0], data};
         end
         // The port offset follows the IHL as soon as its byte arrives, so a
         // zero IHL places the ports on the IHL byte itself.
         ihl_now = (seen_bytes == IHL_OFFSET) ? data[3:0] : cap_ihl;
         port_at = ETH_HDR_BYTES + WORD_BYTES * ihl_now;
         if (seen_bytes == port_at || seen_bytes == port_at + 1) begin
            cap_src_port = {cap_src_port[7:0], data};
         end
         if (seen_bytes == port_at + 2 || seen_bytes == port_at + 3) begin
            cap_dst_port = {cap_dst_port[7:0], data};
         end
         seen_bytes++;
      end
      if (last) begin
         hdr_len = ETH_HDR_BYTES + WORD_BYTES * cap_ihl;
         if (seen_bytes < ETH_HDR_BYTES) begin
            cls = CLASS_SHORT;
         end else if (cap_ether_kind != ETHERTYPE_IPV4) begin
            cls = CLASS_NON_IP;
         end else if (seen_bytes < ETH_HDR_BYTES + IP_MIN_BYTES) begin
            cls = CLASS_IP_TRUNC;
         end else if (seen_bytes < hdr_len) begin
            cls = CLASS_IHL_TRUNC;
         end else if (cap_proto == PROTO_TCP) begin
            cls = (seen_bytes < hdr_len + TCP_MIN_BYTES) ? CLASS_TCP_TRUNC : CLASS_TCP;
         end else if (cap_proto == PROTO_UDP) begin
            cls = (seen_bytes < hdr_len + UDP_MIN_BYTES) ? CLASS_UDP_TRUNC : CLASS_UDP;
         end else begin
            cls = CLASS_OTHER;
         end
         // Fields that carry no meaning for the class come back as zero.
         rec.frame_class  = cls;
         rec.source_mac   = (cls != CLASS_SHORT) ? cap_src_mac : '0;
         rec.dest_mac     = (cls != CLASS_SHORT) ? cap_dst_mac : '0;
         rec.ether_kind   = (cls != CLASS_SHORT) ? cap_ether_kind : '0;
         rec.ip_protocol  = (cls >= CLASS_IP_TRUNC) ? cap_proto : '0;
         rec.source_ip    = (cls >= CLASS_TCP_TRUNC) ? cap_src_ip : '0;
         rec.dest_ip      = (cls >= CLASS_TCP_TRUNC) ? cap_dst_ip : '0;
         rec.source_port  = (cls == CLASS_TCP || cls == CLASS_UDP) ? cap_src_port : '0;
         rec.dest_port    = (cls == CLASS_TCP || cls == CLASS_UDP) ? cap_dst_port : '0;
         rec.frame_length = seen_bytes[FRAME_LENGTH_W-1:0];
         records_due.push_back(rec);
         seen_bytes     = 0;
         cap_dst_mac    = '0;
         cap_src_mac    = '0;
         cap_ether_kind = '0;
         cap_ihl        = '0;
         cap_proto      = '0;
         cap_src_ip     = '0;
         cap_dst_ip     = '0;
         cap_src_port   = '0;
         cap_dst_port   = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Queues one frame of len bytes. With shaped set, the ethertype, the
   // version/IHL byte and the protocol byte are written over the fill; every
   // other byte, addresses and ports included, comes from the fill.
   task automatic add_frame(input int unsigned len, input fill_kind_type fill, input bit shaped,
                            input logic [15:0] ether_kind, input logic [7:0] ver_ihl,
                            input logic [7:0] proto);
      logic [7:0] data;
      for (int unsigned i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: data = 8'h00;
            FILL_ONES: data = 8'hFF;
            default:   data = 8'($urandom);
         endcase
         if (shaped) begin
            if (i == ETH_HDR_BYTES - 2) begin
               data = ether_kind[15:8];
            end else if (i == ETH_HDR_BYTES - 1) begin
               data = ether_kind[7:0];
            end else if (i == IHL_OFFSET) begin
               data = ver_ihl;
            end else if (i == PROTO_OFFSET) begin
               data = proto;
            end
         end
         pending_bytes.push_back('{data: data, last: (i == len - 1)});
      end
      bytes_queued += len;
      frames_queued++;
   endtask

   // An IPv4 frame with a random version nibble and the given IHL.
   task automatic add_ipv4(input int unsigned len, input logic [3:0] ihl,
                           input logic [7:0] proto);
      add_frame(len, FILL_RANDOM, 1'b1, ETHERTYPE_IPV4, {4'($urandom), ihl}, proto);
   endtask

   // Most random frames are IPv4 with a TCP or UDP header, either complete or
   // cut at a random point; the rest are other IPv4 protocols, foreign
   // ethertypes, short IPv4 fragments and plain noise.
   task automatic add_random_frame();
      int unsigned kind;
      int unsigned pick;
      int unsigned ihl;
      int unsigned min_len;
      int unsigned len;
      logic [7:0]  proto;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         pick = $urandom_range(9);
         proto = (pick < 4) ? PROTO_TCP : (pick < 8) ? PROTO_UDP : 8'($urandom);
         ihl = ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
         min_len = ETH_HDR_BYTES + WORD_BYTES * ihl
                   + ((proto == PROTO_TCP) ? TCP_MIN_BYTES : UDP_MIN_BYTES);
         if ($urandom_range(3) == 0) begin
            len = $urandom_range(1, min_len);
         end else begin
            len = min_len + $urandom_range(16);
            if (len < ETH_HDR_BYTES + IP_MIN_BYTES) begin
               len = ETH_HDR_BYTES + IP_MIN_BYTES + $urandom_range(8);
            end
         end
         add_ipv4(len, 4'(ihl), proto);
      end else if (kind == 7) begin
         // Either a single bit away from IPv4 or any other value.
         if ($urandom_range(1) == 0) begin
            add_frame($urandom_range(14, 60), FILL_RANDOM, 1'b1,
                      ETHERTYPE_IPV4 ^ (16'h0001 << $urandom_range(15)),
                      8'($urandom), 8'($urandom));
         end else begin
            add_frame($urandom_range(1, 60), FILL_RANDOM, 1'b0, '0, '0, '0);
         end
      end else if (kind == 8) begin
         add_ipv4($urandom_range(1, 40), 4'($urandom), 8'($urandom));
      end else begin
         add_frame($urandom_range(1, 64), FILL_RANDOM, 1'b0, '0, '0, '0);
      end
   endtask

   // Request driver. A byte is offered only when the channel is empty or the
   // current byte has just been transferred, so a stalled byte never changes
   // and valid never looks at stall. Each transfer is fed to the predictor.
   always @(posedge clock) begin : drive_bytes
      frame_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_frame_byte(req_data_byte, req_last_byte);
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_byte.data;
               req_last_byte <= next_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every record transferred is checked field by field
   // against the oldest record still due; the stall for the next cycle is
   // drawn at the same edge.
   always @(posedge clock) begin : watch_records
      frame_record_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (records_due.size() == 0) begin
               $error("unexpected record: class %0d, length %0d",
                      rsp_frame_class, rsp_frame_length);
               mismatch_count++;
            end else begin
               want = records_due.pop_front();
               check_field("frame_class", want.frame_class, rsp_frame_class);
               check_field("source_mac", want.source_mac, rsp_source_mac);
               check_field("dest_mac", want.dest_mac, rsp_dest_mac);
               check_field("ether_kind", want.ether_kind, rsp_ether_kind);
               check_field("ip_protocol", want.ip_protocol, rsp_ip_protocol);
               check_field("source_ip", want.source_ip, rsp_source_ip);
               check_field("dest_ip", want.dest_ip, rsp_dest_ip);
               check_field("source_port", want.source_port, rsp_source_port);
               check_field("dest_port", want.dest_port, rsp_dest_port);
               check_field("frame_length", want.frame_length, rsp_frame_length);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Stimulus runs in four phases of idling: none, a sparse sender, a slow
   // receiver, and both at a light rate. Queue updates happen on the falling
   // edge so they never race with the clocked driver and monitor. Between
   // phases everything transferred is drained.
   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 71;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 71;
            end
            default: begin
               send_idle_pct  = 18;
               recv_stall_pct = 18;
            end
         endcase
         bytes_queued  = 0;
         frames_queued = 0;
         if (phase == 0) begin
            // A lone last byte, and a frame one byte short of the Ethernet
            // header.
            add_frame(1, FILL_RANDOM, 1'b0, '0, '0, '0);
            add_frame(ETH_HDR_BYTES - 1, FILL_RANDOM, 1'b0, '0, '0, '0);
            // All-zero and all-ones frames, and one a bit off IPv4: all foreign ethertypes.
            add_frame(ETH_HDR_BYTES, FILL_ZERO, 1'b0, '0, '0, '0);
            add_frame(40, FILL_ONES, 1'b0, '0, '0, '0);
            add_frame(40, FILL_RANDOM, 1'b1, ETHERTYPE_IPV4 | 16'h0001, 8'h45, PROTO_TCP);
            // IPv4 cut inside the fixed header, at both of its ends.
            add_ipv4(ETH_HDR_BYTES, 4'd5, PROTO_TCP);
            add_ipv4(ETH_HDR_BYTES + IP_MIN_BYTES - 1, 4'd5, PROTO_UDP);
            // Largest IHL: cut inside the options, then inside TCP, then whole.
            add_ipv4(ETH_HDR_BYTES + IP_MIN_BYTES, 4'd15, PROTO_TCP);
            add_ipv4(74, 4'd15, PROTO_TCP);
            add_ipv4(74 + TCP_MIN_BYTES - 1, 4'd15, PROTO_TCP);
            add_ipv4(74 + TCP_MIN_BYTES, 4'd15, PROTO_TCP);
            // UDP one byte short and exactly complete.
            add_ipv4(34 + UDP_MIN_BYTES - 1, 4'd5, PROTO_UDP);
            add_ipv4(34 + UDP_MIN_BYTES, 4'd5, PROTO_UDP);
            // Other protocols, at the bottom and top of the byte.
            add_ipv4(34, 4'd5, 8'h00);
            add_ipv4(34, 4'd5, 8'hFF);
            // IHL below five: the ports overlap the IPv4 header, and with a
            // zero IHL they start on the IHL byte itself.
            add_ipv4(40, 4'd0, PROTO_UDP);
            add_ipv4(34, 4'd3, PROTO_TCP);
            add_ipv4(50, 4'd3, PROTO_TCP);
            bytes_queued  = 0;
            frames_queued = 0;
         end
         while (bytes_queued < 160 || frames_queued < 3) begin
            add_random_frame();
         end
         while (pending_bytes.size() != 0 || req_valid || records_due.size() != 0) begin
            @(negedge clock);
         end
         repeat (4) @(negedge clock);
      end
      // The record follows the last transfer in the next cycle; a further wait
      // catches any stray record.
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
